/* rtl/core/triangular_matrix_product_sum_macros.svh */
// Assertion macros for the matrix product block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef TRIANGULAR_MATRIX_PRODUCT_SUM_MACROS_SVH
`define TRIANGULAR_MATRIX_PRODUCT_SUM_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TMPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TMPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMPS_ASSERT_IMP(lbl, ante, cons, msg)
`define TMPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/tmps_pkg.sv */
package tmps_pkg;

  localparam int MAX_DIM   = 64;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // field widths
  localparam int KIND_W    = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int ELEM_W    = 16;
  localparam int SIZE_W    = 7;
  localparam int RES_W     = 64;

  // datapath widths
  localparam int PART_W    = 38;               // Q.16 row of A*B
  localparam int PROD_W    = 2 * ELEM_W;       // Q8.8 x Q8.8
  localparam int WPROD_W   = PART_W + ELEM_W;  // partial x Q8.8
  localparam int SQ_W      = 38;
  localparam int ALIGN_SH  = 8;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 80;
  localparam int M_PAD_W   = M_TDATA_W - (ROW_W + COL_W + RES_W);

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  // control word that travels with each MAC step
  typedef struct packed {
    logic             valid;
    logic             ph2;       // second pass: (AB)B^T + A^T A
    logic             first;     // clears the accumulators
    logic             last;      // closes one output column
    logic             do_sq;     // A^T A term active (k <= r)
    logic             last_col;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] r;
  } ctrl_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [RES_W-1:0] value;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic credit_ok;
    logic full;
  } ofifo_stat_t;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    mem_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
  endfunction

endpackage

/* rtl/core/tmps_ram.sv */
module tmps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/core/tmps_seq.sv */
module tmps_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tmps_pkg::KIND_W-1:0]          kind_i,
  input  logic [tmps_pkg::ROW_W-1:0]           row_i,
  input  logic [tmps_pkg::SIZE_W-1:0]          size_i,
  input  logic                                 busy_i,
  input  logic                                 credit_ok_i,
  output tmps_pkg::ctrl_t                      issue_o,
  output logic [tmps_pkg::ADDR_W-1:0]          a0_addr_o,
  output logic [tmps_pkg::ADDR_W-1:0]          a1_addr_o,
  output logic [tmps_pkg::ADDR_W-1:0]          b_addr_o,
  output logic [tmps_pkg::IDX_W-1:0]           p_addr_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_P1    = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_P2    = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [tmps_pkg::IDX_W-1:0]   j_q, j_d, k_q, k_d, r_q, r_d, nm1_q, nm1_d;
  logic [tmps_pkg::SIZE_W-1:0]  eff;
  logic                         start;

  always_comb begin
    if (size_i == '0) begin
      eff = tmps_pkg::SIZE_W'(1);
    end else if (size_i > tmps_pkg::SIZE_W'(tmps_pkg::MAX_DIM)) begin
      eff = tmps_pkg::SIZE_W'(tmps_pkg::MAX_DIM);
    end else begin
      eff = size_i;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign start = in_valid_i && in_ready_o && (kind_i == tmps_pkg::KIND_COMPUTE)
                 && (tmps_pkg::SIZE_W'(row_i) < eff);

  // step issue: second pass waits at each column start for an output slot
  always_comb begin
    issue_o.valid    = (state_q == ST_P1) ||
                       ((state_q == ST_P2) && ((k_q != '0) || credit_ok_i));
    issue_o.ph2      = (state_q == ST_P2);
    issue_o.first    = (state_q == ST_P2) ? (k_q == '0) : (k_q == r_q);
    issue_o.last     = (k_q == nm1_q);
    issue_o.do_sq    = (k_q <= r_q);
    issue_o.last_col = (j_q == nm1_q);
    issue_o.j        = j_q;
    issue_o.r        = r_q;
  end

  always_comb begin
    if (state_q == ST_P2) begin
      a0_addr_o = tmps_pkg::mem_addr(k_q, r_q);
      b_addr_o  = tmps_pkg::mem_addr(j_q, k_q);
    end else begin
      a0_addr_o = tmps_pkg::mem_addr(r_q, k_q);
      b_addr_o  = tmps_pkg::mem_addr(k_q, j_q);
    end
    a1_addr_o = tmps_pkg::mem_addr(k_q, j_q);
    p_addr_o  = k_q;
  end

  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    k_d     = k_q;
    r_d     = r_q;
    nm1_d   = nm1_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_P1;
          r_d     = row_i[tmps_pkg::IDX_W-1:0];
          k_d     = row_i[tmps_pkg::IDX_W-1:0];
          j_d     = '0;
          nm1_d   = tmps_pkg::IDX_W'(eff - tmps_pkg::SIZE_W'(1));
        end
      end
      ST_P1: begin
        if (k_q == nm1_q) begin
          k_d = r_q;
          j_d = j_q + tmps_pkg::IDX_W'(1);
          if (j_q == nm1_q) begin
            state_d = ST_DRAIN;
          end
        end else begin
          k_d = k_q + tmps_pkg::IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // partial row must be fully written before the second pass reads it
        if (!busy_i) begin
          state_d = ST_P2;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_P2: begin
        if (issue_o.valid) begin
          if (k_q == nm1_q) begin
            k_d = '0;
            j_d = j_q + tmps_pkg::IDX_W'(1);
            if (j_q == nm1_q) begin
              state_d = ST_IDLE;
            end
          end else begin
            k_d = k_q + tmps_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      k_q     <= '0;
      r_q     <= '0;
      nm1_q   <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      k_q     <= k_d;
      r_q     <= r_d;
      nm1_q   <= nm1_d;
    end
  end

endmodule

/* rtl/core/tmps_mac.sv */
module tmps_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmps_pkg::ctrl_t               issue_i,
  input  logic [tmps_pkg::ELEM_W-1:0]   a0_data_i,
  input  logic [tmps_pkg::ELEM_W-1:0]   a1_data_i,
  input  logic [tmps_pkg::ELEM_W-1:0]   b_data_i,
  input  logic [tmps_pkg::PART_W-1:0]   p_data_i,
  output logic                          busy_o,
  output logic                          p_we_o,
  output logic [tmps_pkg::IDX_W-1:0]    p_waddr_o,
  output logic [tmps_pkg::PART_W-1:0]   p_wdata_o,
  output logic                          res_valid_o,
  output tmps_pkg::res_t                res_o
);

  tmps_pkg::ctrl_t c1_q, c2_q, c3_q, c3_d;

  logic signed [tmps_pkg::ELEM_W-1:0]  a0, a1, b, mul_rhs;
  logic signed [tmps_pkg::PART_W-1:0]  p;
  logic signed [tmps_pkg::PROD_W-1:0]  m1_d, m1_q;
  logic signed [tmps_pkg::WPROD_W-1:0] m2_d, m2_q;
  logic signed [tmps_pkg::RES_W-1:0]   acc_q, acc_d, acc_add;
  logic signed [tmps_pkg::SQ_W-1:0]    sq_q, sq_d, sq_add;

  assign a0 = $signed(a0_data_i);
  assign a1 = $signed(a1_data_i);
  assign b  = $signed(b_data_i);
  assign p  = $signed(p_data_i);

  // first pass: A[r][k]*B[k][j]; second pass: A[k][r]*A[k][j] and P[k]*B[j][k]
  assign mul_rhs = c1_q.ph2 ? a1 : b;
  assign m1_d    = a0 * mul_rhs;
  assign m2_d    = p * b;

  assign acc_add = c2_q.ph2 ? tmps_pkg::RES_W'(m2_q) : tmps_pkg::RES_W'(m1_q);
  assign sq_add  = (c2_q.ph2 && c2_q.do_sq) ? tmps_pkg::SQ_W'(m1_q) : '0;

  always_comb begin
    acc_d = acc_q;
    sq_d  = sq_q;
    if (c2_q.valid) begin
      acc_d = c2_q.first ? acc_add : acc_q + acc_add;
      sq_d  = c2_q.first ? sq_add : sq_q + sq_add;
    end
    c3_d       = c2_q;
    c3_d.valid = c2_q.valid && c2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else begin
      c1_q <= issue_i;
      c2_q <= c1_q;
      c3_q <= c3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
  end

  assign busy_o = c1_q.valid || c2_q.valid || c3_q.valid;

  assign p_we_o    = c3_q.valid && !c3_q.ph2;
  assign p_waddr_o = c3_q.j;
  assign p_wdata_o = acc_q[tmps_pkg::PART_W-1:0];

  assign res_valid_o = c3_q.valid && c3_q.ph2;
  assign res_o.row   = tmps_pkg::ROW_W'(c3_q.r);
  assign res_o.col   = tmps_pkg::COL_W'(c3_q.j);
  assign res_o.value = acc_q + (tmps_pkg::RES_W'(sq_q) <<< tmps_pkg::ALIGN_SH);
  assign res_o.last  = c3_q.last_col;

endmodule

/* rtl/core/tmps_ofifo.sv */
module tmps_ofifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 reserve_i,
  input  logic                 push_i,
  input  tmps_pkg::res_t       entry_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output tmps_pkg::res_t       entry_o,
  output tmps_pkg::ofifo_stat_t stat_o
);

  tmps_pkg::res_t                   mem_q [tmps_pkg::OFIFO_DEPTH];
  logic [tmps_pkg::OFIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [tmps_pkg::OFIFO_CNT_W-1:0] count_q, count_d, resv_q, resv_d;
  logic                             pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign entry_o = mem_q[rptr_q];

  // slots are reserved when a column starts, so a push always finds room
  assign stat_o.credit_ok = (resv_q < tmps_pkg::OFIFO_CNT_W'(tmps_pkg::OFIFO_DEPTH));
  assign stat_o.full      = (count_q == tmps_pkg::OFIFO_CNT_W'(tmps_pkg::OFIFO_DEPTH));

  always_comb begin
    count_d = count_q;
    resv_d  = resv_q;
    if (push_i && !pop) begin
      count_d = count_q + tmps_pkg::OFIFO_CNT_W'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - tmps_pkg::OFIFO_CNT_W'(1);
    end
    if (reserve_i && !pop) begin
      resv_d = resv_q + tmps_pkg::OFIFO_CNT_W'(1);
    end else if (!reserve_i && pop) begin
      resv_d = resv_q - tmps_pkg::OFIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
      resv_q  <= '0;
    end else begin
      count_q <= count_d;
      resv_q  <= resv_d;
      if (push_i) begin
        wptr_q <= wptr_q + tmps_pkg::OFIFO_PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + tmps_pkg::OFIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/core/triangular_matrix_product_sum.sv */
// Loads are taken only while no compute runs. A compute of row r at size n runs MAC steps
// over the A*B row (k from r), drains, then runs MAC steps over the output row.
// One result leaves per output column; no new transaction is taken until the compute ends.
// All steps share the single MAC pipeline, and each store has one read port.
// Reset clears control and sets size to 64; the A, B and partial-row stores are not cleared.
`include "triangular_matrix_product_sum_macros.svh"

module triangular_matrix_product_sum (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tmps_pkg::SIZE_W-1:0]          cfg_wdata_i,     // size
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [tmps_pkg::S_TDATA_W-1:0]       s_axis_tdata,    // row, col, element_value, pad
  input  logic [tmps_pkg::KIND_W-1:0]          s_axis_tuser,    // kind
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [tmps_pkg::M_TDATA_W-1:0]       m_axis_tdata,    // out_row, out_col, result_value, pad
  output logic                                 m_axis_tlast     // last
);

  logic [tmps_pkg::SIZE_W-1:0] size_q;

  logic [tmps_pkg::ROW_W-1:0]  s_row;
  logic [tmps_pkg::COL_W-1:0]  s_col;
  logic [tmps_pkg::ELEM_W-1:0] s_value;
  logic [tmps_pkg::KIND_W-1:0] s_kind;
  logic                        s_acc, in_range, a_we, b_we;
  logic [tmps_pkg::ADDR_W-1:0] ld_addr;

  tmps_pkg::ctrl_t             issue;
  logic [tmps_pkg::ADDR_W-1:0] a0_addr, a1_addr, b_addr;
  logic [tmps_pkg::IDX_W-1:0]  p_raddr, p_waddr;
  logic [tmps_pkg::ELEM_W-1:0] a0_data, a1_data, b_data;
  logic [tmps_pkg::PART_W-1:0] p_rdata, p_wdata;
  logic                        p_we, busy, res_valid;
  tmps_pkg::res_t              res, out_entry;
  tmps_pkg::ofifo_stat_t       ofifo_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= tmps_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  assign s_row   = s_axis_tdata[tmps_pkg::ROW_W-1:0];
  assign s_col   = s_axis_tdata[tmps_pkg::ROW_W +: tmps_pkg::COL_W];
  assign s_value = s_axis_tdata[tmps_pkg::ROW_W + tmps_pkg::COL_W +: tmps_pkg::ELEM_W];
  assign s_kind  = s_axis_tuser;
  assign s_acc   = s_axis_tvalid && s_axis_tready;

  assign in_range = (tmps_pkg::SIZE_W'(s_row) < tmps_pkg::SIZE_W'(tmps_pkg::MAX_DIM)) &&
                    (tmps_pkg::SIZE_W'(s_col) < tmps_pkg::SIZE_W'(tmps_pkg::MAX_DIM));
  assign a_we    = s_acc && in_range && (s_kind == tmps_pkg::KIND_LOAD_A);
  assign b_we    = s_acc && in_range && (s_kind == tmps_pkg::KIND_LOAD_B);
  assign ld_addr = tmps_pkg::mem_addr(s_row[tmps_pkg::IDX_W-1:0],
                                      s_col[tmps_pkg::IDX_W-1:0]);

  tmps_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_kind),
    .row_i       (s_row),
    .size_i      (size_q),
    .busy_i      (busy),
    .credit_ok_i (ofifo_stat.credit_ok),
    .issue_o     (issue),
    .a0_addr_o   (a0_addr),
    .a1_addr_o   (a1_addr),
    .b_addr_o    (b_addr),
    .p_addr_o    (p_raddr)
  );

  // A is held twice so the second pass can read two entries per cycle
  tmps_ram #(.WIDTH(tmps_pkg::ELEM_W), .DEPTH(tmps_pkg::MEM_DEPTH)) u_a0_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (ld_addr),
    .wdata_i (s_value),
    .raddr_i (a0_addr),
    .rdata_o (a0_data)
  );

  tmps_ram #(.WIDTH(tmps_pkg::ELEM_W), .DEPTH(tmps_pkg::MEM_DEPTH)) u_a1_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (ld_addr),
    .wdata_i (s_value),
    .raddr_i (a1_addr),
    .rdata_o (a1_data)
  );

  tmps_ram #(.WIDTH(tmps_pkg::ELEM_W), .DEPTH(tmps_pkg::MEM_DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (ld_addr),
    .wdata_i (s_value),
    .raddr_i (b_addr),
    .rdata_o (b_data)
  );

  tmps_ram #(.WIDTH(tmps_pkg::PART_W), .DEPTH(tmps_pkg::MAX_DIM)) u_p_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  tmps_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .a0_data_i   (a0_data),
    .a1_data_i   (a1_data),
    .b_data_i    (b_data),
    .p_data_i    (p_rdata),
    .busy_o      (busy),
    .p_we_o      (p_we),
    .p_waddr_o   (p_waddr),
    .p_wdata_o   (p_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tmps_ofifo u_ofifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .reserve_i (issue.valid && issue.ph2 && issue.first),
    .push_i    (res_valid),
    .entry_i   (res),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .entry_o   (out_entry),
    .stat_o    (ofifo_stat)
  );

  assign m_axis_tdata = {{tmps_pkg::M_PAD_W{1'b0}}, out_entry.value,
                         out_entry.col, out_entry.row};
  assign m_axis_tlast = out_entry.last;

  `TMPS_ASSERT_IMP(a_pwr_not_in_p2, p_we, !(issue.valid && issue.ph2), "partial row written during second pass")
  `TMPS_ASSERT_IMP(a_push_has_room, res_valid, !ofifo_stat.full || (m_axis_tvalid && m_axis_tready), "result pushed into full queue")
  `TMPS_ASSERT_NXT(a_compute_holds, s_acc && (s_kind == tmps_pkg::KIND_COMPUTE) && (s_row == '0), !s_axis_tready, "compute of row 0 did not start")

endmodule

/* tb/triangular_matrix_product_sum_checker.sv */
`timescale 1ns / 100ps

module triangular_matrix_product_sum_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmps_pkg::SIZE_W-1:0]       cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [tmps_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // row, col, element_value, pad
  input  logic [tmps_pkg::KIND_W-1:0]       s_axis_tuser,   // kind
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [tmps_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // out_row, out_col, result_value, pad
  input  logic                              m_axis_tlast,   // last
  output int                                mismatch_count_o,
  output int                                outstanding_o
);
  import tmps_pkg::*;

  logic signed [ELEM_W-1:0] a_mat [MEM_DEPTH];
  logic signed [ELEM_W-1:0] b_mat [MEM_DEPTH];
  logic [SIZE_W-1:0]        size_reg;
  res_t                     c_elems_q [$];

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
    for (int i = 0; i < MEM_DEPTH; i++) begin
      a_mat[i] = '0;
      b_mat[i] = '0;
    end
  end

  // size 0 behaves as 1, anything above the store dimension as the full store
  function automatic int active_dim();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_DIM) return MAX_DIM;
    return int'(size_reg);
  endfunction

  task automatic report(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("%s", msg);
  endtask

  // Row r of C = (A*B)*B^T + A^T*A, with the triangular limits on k
  task automatic compute_c_row(input int r);
    longint ab_row [MAX_DIM];
    longint acc;
    longint sq;
    int     n;
    res_t   elem;
    n = active_dim();
    for (int j = 0; j < n; j++) begin
      acc = 0;
      for (int k = r; k < n; k++)
        acc += longint'(a_mat[r*MAX_DIM+k]) * longint'(b_mat[k*MAX_DIM+j]);
      ab_row[j] = acc;
    end
    for (int j = 0; j < n; j++) begin
      acc = 0;
      sq  = 0;
      for (int k = 0; k < n; k++)
        acc += ab_row[k] * longint'(b_mat[j*MAX_DIM+k]);
      for (int k = 0; k <= r; k++)
        sq += longint'(a_mat[k*MAX_DIM+r]) * longint'(a_mat[k*MAX_DIM+j]);
      acc += sq * 256;
      elem.row   = ROW_W'(r);
      elem.col   = COL_W'(j);
      elem.value = acc;
      elem.last  = (j == n - 1);
      c_elems_q.push_back(elem);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t  got;
    res_t  want;
    kind_e kind;
    int    row;
    int    col;
    if (!rst_ni) begin
      size_reg = SIZE_RESET;
      c_elems_q.delete();
      outstanding_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.row   = m_axis_tdata[ROW_W-1:0];
        got.col   = m_axis_tdata[ROW_W+COL_W-1:ROW_W];
        got.value = m_axis_tdata[ROW_W+COL_W+RES_W-1:ROW_W+COL_W];
        got.last  = m_axis_tlast;
        if (c_elems_q.size() == 0) begin
          report($sformatf("unexpected result: row %0d col %0d value %0d last %0b",
                           got.row, got.col, $signed(got.value), got.last));
        end else begin
          want = c_elems_q.pop_front();
          if (got !== want)
            report($sformatf({"mismatch: expected row %0d col %0d value %0d last %0b, ",
                              "got row %0d col %0d value %0d last %0b"},
                             want.row, want.col, $signed(want.value), want.last,
                             got.row, got.col, $signed(got.value), got.last));
        end
      end
      if (cfg_we_i) size_reg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        kind = kind_e'(s_axis_tuser);
        row  = int'(s_axis_tdata[ROW_W-1:0]);
        col  = int'(s_axis_tdata[ROW_W+COL_W-1:ROW_W]);
        case (kind)
          KIND_LOAD_A: begin
            a_mat[row*MAX_DIM+col] = s_axis_tdata[ROW_W+COL_W+ELEM_W-1:ROW_W+COL_W];
          end
          KIND_LOAD_B: begin
            b_mat[row*MAX_DIM+col] = s_axis_tdata[ROW_W+COL_W+ELEM_W-1:ROW_W+COL_W];
          end
          KIND_COMPUTE: begin
            if (row < active_dim()) compute_c_row(row);
          end
          default: ;
        endcase
      end
      outstanding_o = c_elems_q.size();
    end
  end

endmodule

/* tb/triangular_matrix_product_sum_tb.sv */
`timescale 1ns / 100ps

module triangular_matrix_product_sum_tb;
  import tmps_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 160;
  localparam int PHASE_ITEMS  = 40;
  localparam int S_PAD_W      = S_TDATA_W - ROW_W - COL_W - ELEM_W;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [SIZE_W-1:0]    cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [KIND_W-1:0]    s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int mismatches;
  int outstanding;
  int dim;          // matrix dimension the block is working at
  int random_done;
  bit s_steady;
  bit m_steady;
  bit a_loaded [MEM_DEPTH];
  bit b_loaded [MEM_DEPTH];

  triangular_matrix_product_sum u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  triangular_matrix_product_sum_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_axis_tvalid    (s_tvalid),
    .s_axis_tready    (s_tready),
    .s_axis_tdata     (s_tdata),
    .s_axis_tuser     (s_tuser),
    .m_axis_tvalid    (m_tvalid),
    .m_axis_tready    (m_tready),
    .m_axis_tdata     (m_tdata),
    .m_axis_tlast     (m_tlast),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (s_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input logic [KIND_W-1:0] kind, input int row, input int col,
                           input logic [ELEM_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{S_PAD_W{1'b0}}, value, COL_W'(col), ROW_W'(row)};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (kind == KIND_LOAD_A) a_loaded[row*MAX_DIM+col] = 1'b1;
    if (kind == KIND_LOAD_B) b_loaded[row*MAX_DIM+col] = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic compute_row(input int row);
    send_item(KIND_COMPUTE, row, $urandom_range(0, 63), pick_elem());
  endtask

  // every entry a compute at this size can read gets loaded before use
  task automatic load_region();
    for (int r = 0; r < dim; r++)
      for (int c = 0; c < dim; c++) begin
        if (!a_loaded[r*MAX_DIM+c]) send_item(KIND_LOAD_A, r, c, pick_elem());
        if (!b_loaded[r*MAX_DIM+c]) send_item(KIND_LOAD_B, r, c, pick_elem());
      end
  endtask

  // drain all results, then give a dropped compute time to finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (2 * dim * dim + 16) @(negedge clk_i);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    dim = (value == 0) ? 1 : (value > MAX_DIM) ? MAX_DIM : int'(value);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_item(KIND_W'($urandom_range(0, 1)), $urandom_range(0, dim - 1),
                $urandom_range(0, dim - 1), pick_elem());
      random_done++;
    end else if (pick < 60) begin
      send_item(KIND_W'($urandom_range(0, 1)), $urandom_range(0, 63),
                $urandom_range(0, 63), pick_elem());
      random_done++;
    end else if (pick < 85) begin
      compute_row($urandom_range(0, dim - 1));
      random_done++;
    end else if (pick < 93 && dim < MAX_DIM) begin
      compute_row($urandom_range(dim, 63));
    end else begin
      send_item(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), pick_elem());
    end
  endtask

  initial begin : sink
    int stall;
    int tick;
    m_tready = 1'b0;
    m_steady = 1'b0;
    stall    = 0;
    tick     = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 256 == 0) m_steady = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!m_steady && $urandom_range(0, 99) < 30)
          stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
    end
  end

  initial begin : source
    logic [SIZE_W-1:0] next_size;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    dim         = MAX_DIM;
    random_done = 0;
    s_steady    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ignored kind and loads at the corners of the store
    send_item(KIND_UNUSED, 63, 63, 16'hffff);
    send_item(KIND_LOAD_A, 63, 63, 16'h7fff);
    send_item(KIND_LOAD_B, 63, 0, 16'h8000);
    send_item(KIND_LOAD_B, 0, 63, 16'h7fff);

    // size 0 acts as 1; rows past the size emit nothing
    set_size(0);
    send_item(KIND_LOAD_A, 0, 0, 16'h8000);
    send_item(KIND_LOAD_B, 0, 0, 16'h8000);
    compute_row(0);
    compute_row(1);
    compute_row(63);
    set_size(1);
    compute_row(0);
    send_item(KIND_LOAD_A, 0, 0, 16'h7fff);
    compute_row(0);

    set_size(3);
    load_region();
    compute_row(0);
    compute_row(1);
    compute_row(2);
    compute_row(3);
    send_item(KIND_UNUSED, 0, 0, 16'h0000);

    // oversize setting, then loads at the far edge of the store
    set_size(7'd127);
    send_item(KIND_LOAD_A, 0, 63, 16'h8000);
    send_item(KIND_LOAD_B, 63, 63, 16'h8000);

    while (random_done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       next_size = 0;
        1:       next_size = 1;
        2:       next_size = SIZE_W'($urandom_range(7, 8));
        default: next_size = SIZE_W'($urandom_range(2, 6));
      endcase
      set_size(next_size);
      s_steady = ($urandom_range(0, 3) == 0);
      load_region();
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
